// ===== hw/rtl/uvsph_pkg.sv =====
// uvsph_pkg: shared types and constants of the UV sphere mesh generator.
// Depends on nothing.
`default_nettype none
package uvsph_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRadius   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSegments = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRings    = 2'd2;

  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;

  // atan(2^-i) in Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      default: v = 34'sd1048576 >>> (i - 5'd10);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uv_sphere_mesh_generator.sv =====
// uv_sphere_mesh_generator: streams a UV sphere mesh, one element per tick item.
// Depends on uvsph_pkg. One sequencer shares a divider, a CORDIC and a multiplier.
//
//  channel  | dir | handshake                | payload
//  s_axis   | in  | s_axis_tvalid/tready     | tdata[0] restart
//  m_axis   | out | m_axis_tvalid/tready     | tdata vertex/index fields, tuser kind, tlast
//  cfg      | in  | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A vertex item passes through load, two 33-step divisions for the angles, two
// 17-step divisions for u and v, two CORDIC passes, the normal and position
// multiplies and the output state. An index item passes through load, index and
// output. s_axis_tready is high only in the idle state, so a new item is taken
// only after the last one has been loaded into the output register.
// Reset clears the sequence position and loads register defaults.
// While the output register is held, the sequencer waits in its output state.
`default_nettype none
module uv_sphere_mesh_generator #(
  parameter int unsigned MAX_SEGMENTS      = 64,
  parameter int unsigned MAX_RINGS         = 64,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [0] restart
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, vertex_index,
  // zero pad
  output logic [151:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // element_kind
  output logic              m_axis_tlast,   // last
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDiv   = 9'b000000010,
    StAng   = 9'b000000100,
    StCord  = 9'b000001000,
    StMul   = 9'b000010000,
    StPos   = 9'b000100000,
    StIdx   = 9'b001000000,
    StOut   = 9'b010000000,
    StLoad  = 9'b100000000
  } state_e;

  // ---------------- configuration
  logic [15:0] radius_q;
  logic [6:0]  segcfg_q, ringcfg_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256; segcfg_q <= 7'd16; ringcfg_q <= 7'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        uvsph_pkg::CfgRadius:   radius_q  <= cfg_data_i;
        uvsph_pkg::CfgSegments: segcfg_q  <= cfg_data_i[6:0];
        uvsph_pkg::CfgRings:    ringcfg_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS > MAX_RINGS ?
                                        MAX_SEGMENTS + 1 : MAX_RINGS + 1);
  localparam int unsigned ItW  = $clog2(CORDIC_ITERATIONS + 1);
  localparam logic [CntW-1:0] MaxSegs  = CntW'(MAX_SEGMENTS);
  localparam logic [CntW-1:0] MaxRings = CntW'(MAX_RINGS);

  // effective counts
  logic [CntW-1:0] segs, rings, segc, ringc;
  always_comb begin
    segc  = CntW'(segcfg_q);
    ringc = CntW'(ringcfg_q);
    segs  = (segcfg_q < 7'd3) ? CntW'(3) : ((segc > MaxSegs && CntW > 7) ||
            (CntW <= 7 && segcfg_q > 7'(MAX_SEGMENTS)) ? MaxSegs : segc);
    rings = (ringcfg_q < 7'd2) ? CntW'(2) : ((ringc > MaxRings && CntW > 7) ||
            (CntW <= 7 && ringcfg_q > 7'(MAX_RINGS)) ? MaxRings : ringc);
  end

  // ---------------- state
  state_e          st_q;
  logic            phase_q;
  logic [CntW-1:0] ring_q, seg_q;
  logic [2:0]      slot_q;
  logic [CntW-1:0] r_q, s_q;          // clamped position of current item
  logic [1:0]      job_q;             // 0 th, 1 ph, 2 u, 3 v
  // divider: numerator / denominator, 33 quotient bits
  logic [47:0]     rem_q;
  logic [32:0]     quo_q;
  logic [5:0]      dcnt_q;
  logic [CntW-1:0] den_q;
  logic [31:0]     th_q, ph_q;
  logic [16:0]     u_q, v_q;
  // cordic
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [ItW-1:0]     it_q;
  logic               angsel_q;       // 0 theta, 1 phi
  logic signed [33:0] cth_q, sth_q, cph_q, sph_q;
  // multiplier sequencing
  logic [2:0]         mstep_q;
  logic signed [16:0] n_q [3];
  logic signed [16:0] p_q [3];
  logic [12:0]        idx_q;
  logic               kind_q, last_q;
  // output register
  logic [151:0]       tdata_q;
  logic               tuser_q, tlast_q;
  logic [151:0]       elem_d;
  logic               out_load;

  assign s_axis_tready = (st_q == StIdle);
  assign out_load      = (st_q == StOut) && (!m_axis_tvalid || m_axis_tready);

  // one shared signed multiplier for the normal and position products
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;
  assign mprod = ma * mb;

  logic [CntW-1:0] rpos, spos;
  always_comb begin
    rpos = ring_q > rings ? rings : ring_q;
    spos = seg_q > segs ? segs : seg_q;
  end

  // angle quadrant split
  logic [31:0]        ang;
  logic [29:0]        qfrac;
  logic [60:0]        zprod;
  assign ang   = angsel_q ? ph_q : th_q;
  assign qfrac = ang[29:0];
  assign zprod = 61'(qfrac) * 61'(uvsph_pkg::HalfPiQ30);

  // cordic step
  logic signed [33:0] dx, dy, at;
  assign dx = cy_q >>> it_q;
  assign dy = cx_q >>> it_q;
  assign at = uvsph_pkg::atan_q30(5'(it_q));

  // quadrant map
  logic signed [33:0] qc, qs, rx, ry;
  always_comb begin
    rx = (qfrac == '0) ? uvsph_pkg::OneQ30 : cx_q;
    ry = (qfrac == '0) ? 34'sd0 : cy_q;
    case (ang[31:30])
      2'd0: begin qc = rx;  qs = ry;  end
      2'd1: begin qc = -ry; qs = rx;  end
      2'd2: begin qc = -rx; qs = -ry; end
      default: begin qc = ry; qs = -rx; end
    endcase
  end

  function automatic logic signed [16:0] clampn(input logic signed [33:0] v);
    if (v > 34'sd16384) return 17'sd16384;
    if (v < -34'sd16384) return -17'sd16384;
    return 17'(v);
  endfunction

  // index arithmetic (small operands)
  logic [CntW-1:0] ri, si, segm1, ringm1;
  logic [2:0]      slot;
  logic [1:0]      corner;
  logic [2*CntW+1:0] idxv;
  always_comb begin
    segm1  = segs - 1'b1;
    ringm1 = rings - 1'b1;
    ri   = ring_q > ringm1 ? ringm1 : ring_q;
    si   = seg_q > segm1 ? segm1 : seg_q;
    slot = slot_q > 3'd5 ? 3'd5 : slot_q;
    case (slot)
      3'd0: corner = 2'd0;
      3'd1: corner = 2'd1;
      3'd2: corner = 2'd2;
      3'd3: corner = 2'd1;
      3'd4: corner = 2'd3;
      default: corner = 2'd2;
    endcase
    idxv = (2*CntW+2)'(ri) * (2*CntW+2)'(segs + 1'b1) + (2*CntW+2)'(si)
         + (2*CntW+2)'(corner[0]) + (corner[1] ? (2*CntW+2)'(segs + 1'b1) : '0);
  end

  // divider trial subtract
  logic [47:0] trial;
  logic [47:0] rem2;
  assign rem2  = {rem_q[46:0], 1'b0};
  assign trial = rem2 - {(48-CntW)'(0), den_q} ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; phase_q <= 1'b0; ring_q <= '0; seg_q <= '0; slot_q <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (st_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tdata[0]) begin
              phase_q <= 1'b0; ring_q <= '0; seg_q <= '0; slot_q <= '0;
            end
            st_q <= StLoad;
          end
        end
        StLoad: begin
          if (phase_q) st_q <= StIdx;
          else begin
            r_q <= rpos; s_q <= spos;
            job_q <= 2'd0; st_q <= StDiv; dcnt_q <= '0;
            // theta: s*2^32/S -> numerator shifted in bit by bit
            rem_q <= 48'(spos); quo_q <= '0; den_q <= segs;
          end
        end
        StDiv: begin
          // restoring division of (num << steps) by den
          if (trial[47] == 1'b0) begin
            rem_q <= trial; quo_q <= {quo_q[31:0], 1'b1};
          end else begin
            rem_q <= rem2; quo_q <= {quo_q[31:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd32) st_q <= StAng;
        end
        StAng: begin
          // quotient is num*2^33/den for the angle jobs (one extra bit); pick per job.
          // A full count (s == S or r == R) divides exactly and is set directly.
          case (job_q)
            2'd0: begin
              th_q <= (s_q >= segs) ? 32'd0 : quo_q[32:1];
              job_q <= 2'd1; st_q <= StDiv; dcnt_q <= '0;
              rem_q <= 48'(r_q); quo_q <= '0; den_q <= rings;
            end
            2'd1: begin
              ph_q <= (r_q >= rings) ? 32'h8000_0000 : {1'b0, quo_q[32:2]};
              job_q <= 2'd2; st_q <= StDiv; dcnt_q <= 6'd16;
              // 17 steps give s*2^17/S; rounding takes the low bit
              rem_q <= 48'(s_q);
              quo_q <= '0; den_q <= segs;
            end
            2'd2: begin
              u_q <= (s_q >= segs) ? 17'd65536 :
                     17'(({1'b0, quo_q[16:0]} + 18'd1) >> 1);
              job_q <= 2'd3; st_q <= StDiv; dcnt_q <= 6'd16;
              rem_q <= 48'(r_q);
              quo_q <= '0; den_q <= rings;
            end
            default: begin
              v_q <= (r_q >= rings) ? 17'd65536 :
                     17'(({1'b0, quo_q[16:0]} + 18'd1) >> 1);
              angsel_q <= 1'b0; it_q <= '0; st_q <= StCord;
              cx_q <= uvsph_pkg::GainQ30; cy_q <= '0;
              cz_q <= 34'(61'(th_q[29:0]) * 61'(uvsph_pkg::HalfPiQ30) >> 30);
            end
          endcase
        end
        StCord: begin
          if (it_q == ItW'(CORDIC_ITERATIONS)) begin
            if (!angsel_q) begin
              cth_q <= qc; sth_q <= qs;
              angsel_q <= 1'b1; it_q <= '0;
              cx_q <= uvsph_pkg::GainQ30; cy_q <= '0;
              cz_q <= 34'(61'(ph_q[29:0]) * 61'(uvsph_pkg::HalfPiQ30) >> 30);
            end else begin
              cph_q <= qc; sph_q <= qs; mstep_q <= '0; st_q <= StMul;
            end
          end else begin
            if (!cz_q[33]) begin
              cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - at;
            end else begin
              cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + at;
            end
            it_q <= it_q + 1'b1;
          end
        end
        StMul: begin
          case (mstep_q)
            3'd0: begin
              n_q[0] <= clampn(34'((mprod + (68'sd1 <<< 45)) >>> 46));
              mstep_q <= 3'd1;
            end
            3'd1: begin
              n_q[2] <= clampn(34'((mprod + (68'sd1 <<< 45)) >>> 46));
              n_q[1] <= clampn((cph_q + 34'sd32768) >>> 16);
              mstep_q <= 3'd2;
            end
            default: begin
              mstep_q <= '0; st_q <= StPos;
            end
          endcase
        end
        StPos: begin
          p_q[mstep_q[1:0]] <= 17'((mprod + 68'sd8192) >>> 14);
          mstep_q <= mstep_q + 3'd1;
          if (mstep_q == 3'd2) begin
            kind_q <= 1'b0; last_q <= 1'b0; idx_q <= '0; st_q <= StOut;
            slot_q <= '0;
            if (s_q >= segs) begin
              seg_q <= '0;
              if (r_q >= rings) begin phase_q <= 1'b1; ring_q <= '0; end
              else ring_q <= r_q + 1'b1;
            end else begin
              seg_q <= s_q + 1'b1; ring_q <= r_q;
            end
          end
        end
        StIdx: begin
          kind_q <= 1'b1; idx_q <= 13'(idxv);
          last_q <= (slot == 3'd5) && (ri == ringm1) && (si == segm1);
          n_q[0] <= '0; n_q[1] <= '0; n_q[2] <= '0;
          p_q[0] <= '0; p_q[1] <= '0; p_q[2] <= '0;
          u_q <= '0; v_q <= '0;
          if (slot == 3'd5) begin
            slot_q <= '0;
            if (si >= segm1) begin
              seg_q <= '0;
              if (ri >= ringm1) begin phase_q <= 1'b0; ring_q <= '0; end
              else ring_q <= ri + 1'b1;
            end else begin
              seg_q <= si + 1'b1; ring_q <= ri;
            end
          end else begin
            slot_q <= slot + 3'd1; ring_q <= ri; seg_q <= si;
          end
          st_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            tdata_q <= elem_d; tuser_q <= kind_q; tlast_q <= last_q;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    ma = sph_q; mb = cth_q;
    if (st_q == StMul && mstep_q == 3'd1) mb = sth_q;
    if (st_q == StPos) begin
      ma = 34'(n_q[mstep_q[1:0]]);
      mb = 34'(radius_q);
    end
  end

  assign elem_d = {6'd0, idx_q, v_q, u_q,
                   16'(n_q[2]), 16'(n_q[1]), 16'(n_q[0]),
                   p_q[2], p_q[1], p_q[0]};
  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;
  assign m_axis_tlast = tlast_q;

  // output register holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last on vertex element");

endmodule
`default_nettype wire

// ===== sim/uv_sphere_mesh_checker.sv =====
// Checker for the UV sphere mesh generator: watches the tick, mesh and register
// channels, predicts every mesh element and compares it field by field. Uses uvsph_pkg.
`timescale 1ns / 1ps
module uv_sphere_mesh_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [151:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           mismatch_count_o,
  output int           elems_pending_o
);

  typedef struct packed {
    logic        kind;
    logic [16:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic [16:0] tu, tv;
    logic [12:0] idx;
    logic        last;
  } mesh_elem_t;

  localparam longint OneFix  = 64'sd1073741824;
  localparam longint GainFix = 64'sd652032874;

  mesh_elem_t mesh_elems_q[$];
  longint     atan_tab[16];
  // model copy of registers and sequence position
  logic [15:0] radius;
  logic [6:0]  seg_reg, ring_reg;
  logic        in_index_phase;
  int          ring_at, seg_at, slot_at;

  initial begin
    atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                 131072, 65536, 32768};
  end

  // rotation-mode CORDIC sine/cosine of a turn fraction, Q2.30
  function automatic void turn_sin_cos(input logic [31:0] turn, output longint c,
                                       output longint s);
    longint unsigned q;
    longint x, y, z, dx, dy;
    q = {34'd0, turn[29:0]};
    x = OneFix;
    y = 0;
    if (q != 0) begin
      z = longint'((q * 64'd1686629713) >> 30);
      x = GainFix;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
    end
    case (turn[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // next mesh element for one tick item; advances the sequence position
  function automatic mesh_elem_t next_mesh_elem(input logic restart);
    mesh_elem_t e;
    int segs, rings, r, s, corner, slot;
    longint cth, sth, cph, sph, pv;
    longint n[3];
    longint unsigned th;
    logic [31:0] ph;
    segs  = (seg_reg < 3) ? 3 : ((seg_reg > 64) ? 64 : seg_reg);
    rings = (ring_reg < 2) ? 2 : ((ring_reg > 64) ? 64 : ring_reg);
    e = '0;
    if (restart) begin
      in_index_phase = 1'b0; ring_at = 0; seg_at = 0; slot_at = 0;
    end
    if (!in_index_phase) begin
      r = (ring_at > rings) ? rings : ring_at;
      s = (seg_at > segs) ? segs : seg_at;
      th = (longint'(s) << 32) / segs;
      ph = 32'((longint'(r) << 31) / rings);
      turn_sin_cos(th[31:0], cth, sth);
      turn_sin_cos(ph, cph, sph);
      n[0] = clamp_unit((cth * sph + (64'sd1 << 45)) >>> 46);
      n[1] = clamp_unit((cph + (64'sd1 << 15)) >>> 16);
      n[2] = clamp_unit((sth * sph + (64'sd1 << 45)) >>> 46);
      pv = (n[0] * longint'(radius) + 8192) >>> 14; e.px = pv[16:0];
      pv = (n[1] * longint'(radius) + 8192) >>> 14; e.py = pv[16:0];
      pv = (n[2] * longint'(radius) + 8192) >>> 14; e.pz = pv[16:0];
      e.nx = n[0][15:0];
      e.ny = n[1][15:0];
      e.nz = n[2][15:0];
      pv = ((longint'(s) << 16) + segs / 2) / segs;  e.tu = pv[16:0];
      pv = ((longint'(r) << 16) + rings / 2) / rings; e.tv = pv[16:0];
      slot_at = 0;
      if (s >= segs) begin
        s = 0;
        if (r >= rings) begin
          in_index_phase = 1'b1; r = 0;
        end else begin
          r++;
        end
      end else begin
        s++;
      end
    end else begin
      slot = (slot_at > 5) ? 5 : slot_at;
      r = (ring_at > rings - 1) ? rings - 1 : ring_at;
      s = (seg_at > segs - 1) ? segs - 1 : seg_at;
      // quad winding i0,i1,i2,i1,i3,i2
      case (slot)
        0: corner = 0;
        1, 3: corner = 1;
        2, 5: corner = 2;
        default: corner = 3;
      endcase
      pv = r * (segs + 1) + s + (corner & 1) + ((corner >> 1) ? segs + 1 : 0);
      e.kind = 1'b1;
      e.idx  = pv[12:0];
      e.last = (slot == 5 && r == rings - 1 && s == segs - 1);
      if (slot == 5) begin
        slot = 0;
        if (s >= segs - 1) begin
          s = 0;
          if (r >= rings - 1) begin
            in_index_phase = 1'b0; r = 0;
          end else begin
            r++;
          end
        end else begin
          s++;
        end
      end else begin
        slot++;
      end
      slot_at = slot;
    end
    ring_at = r;
    seg_at  = s;
    return e;
  endfunction

  function automatic string elem_str(input mesh_elem_t e);
    return $sformatf("kind=%0d pos=%h,%h,%h nrm=%h,%h,%h uv=%h,%h idx=%0d last=%0d",
                     e.kind, e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.tu, e.tv, e.idx,
                     e.last);
  endfunction

  assign elems_pending_o = mesh_elems_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    mesh_elem_t got, want, predicted;
    if (!rst_ni) begin
      radius = 16'd256; seg_reg = 7'd16; ring_reg = 7'd8;
      in_index_phase = 1'b0; ring_at = 0; seg_at = 0; slot_at = 0;
      mesh_elems_q.delete();
      mismatch_count_o = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          uvsph_pkg::CfgRadius:   radius   = cfg_data;
          uvsph_pkg::CfgSegments: seg_reg  = cfg_data[6:0];
          uvsph_pkg::CfgRings:    ring_reg = cfg_data[6:0];
          default: ;
        endcase
      end
      // accepted tick item
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = next_mesh_elem(s_axis_tdata[0]);
        mesh_elems_q = {mesh_elems_q, predicted};
      end
      // accepted mesh element
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.px   = m_axis_tdata[16:0];
        got.py   = m_axis_tdata[33:17];
        got.pz   = m_axis_tdata[50:34];
        got.nx   = m_axis_tdata[66:51];
        got.ny   = m_axis_tdata[82:67];
        got.nz   = m_axis_tdata[98:83];
        got.tu   = m_axis_tdata[115:99];
        got.tv   = m_axis_tdata[132:116];
        got.idx  = m_axis_tdata[145:133];
        got.last = m_axis_tlast;
        if (mesh_elems_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: element with none expected: %s", $realtime, elem_str(got));
          mismatch_count_o++;
        end else begin
          want = mesh_elems_q.pop_front();
          if (got !== want) begin
            if (mismatch_count_o < 10)
              $display("%0t: mismatch\n  exp %s\n  got %s", $realtime, elem_str(want),
                       elem_str(got));
            mismatch_count_o++;
          end
        end
      end
    end
  end

endmodule

// ===== sim/uv_sphere_mesh_generator_tb.sv =====
// Testbench top for the UV sphere mesh generator: drives tick items and register
// writes with random idling; uv_sphere_mesh_checker predicts and compares.
`timescale 1ns / 1ps
module uv_sphere_mesh_generator_tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [0] restart
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, vertex_index
  logic [151:0] m_axis_tdata;
  logic         m_axis_tuser;        // element_kind
  logic         m_axis_tlast;        // last
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  int mismatch_count, elems_pending;
  bit tick_idle, sink_idle;
  int sink_hold;   // long hold-off request, in cycles

  uv_sphere_mesh_generator i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  uv_sphere_mesh_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid(cfg_valid_i), .cfg_ready(cfg_ready_o), .cfg_index(cfg_index_i),
    .cfg_data(cfg_data_i),
    .mismatch_count_o(mismatch_count), .elems_pending_o(elems_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_gap(input bit enable);
    int pick;
    pick = $urandom_range(0, 99);
    if (!enable || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mesh sink: random stalls plus the long hold-off
  always @(posedge clk_i) begin
    int stall_left;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = idle_gap(sink_idle);
      m_axis_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_mesh(input logic [15:0] rad, input logic [6:0] segs,
                          input logic [6:0] rings);
    while (elems_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(uvsph_pkg::CfgRadius, rad);
    write_reg(uvsph_pkg::CfgSegments, {9'd0, segs});
    write_reg(uvsph_pkg::CfgRings, {9'd0, rings});
    cfg_valid_i <= 1'b0;
  endtask

  // restart_odds: one in that many items carries restart; 1 means every item
  task automatic send_ticks(input int count, input int restart_odds, input bit first_restart);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = idle_gap(tick_idle);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {7'd0, (i == 0 && first_restart) ||
                               ($urandom_range(1, restart_odds) == 1)};
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // run limit
  initial begin
    #40ms;
    $display("uv_sphere_mesh_generator_tb NOT OK");
    $finish;
  end

  initial begin
    logic [15:0] rad;
    logic [6:0]  segs, rings;
    sink_hold = 0;
    tick_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, then smallest mesh at full radius
    send_ticks(5, 1000, 1'b1);
    set_mesh(16'hFFFF, 7'd0, 7'd1);
    send_ticks(20, 8, 1'b0);

    // random phases; counts are often changed mid-sequence
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 3))
        0: rad = 16'hFFFF;
        1: rad = 16'h0000;
        default: rad = 16'($urandom);
      endcase
      segs  = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6));
      rings = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5));
      if (ph == 5) begin
        segs = 7'd127; rings = 7'd127;
      end
      set_mesh(rad, segs, rings);
      tick_idle = ph[0];
      sink_idle = (ph % 3) != 0;
      if (ph == 3) begin
        tick_idle = 1'b0;
        sink_hold = 1500;
      end
      send_ticks(140, 60, 1'b0);
    end

    while (elems_pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && elems_pending == 0)
      $display("uv_sphere_mesh_generator_tb OK");
    else
      $display("uv_sphere_mesh_generator_tb NOT OK");
    $finish;
  end

endmodule
